FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every edge out of reset.
`define CHK_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant check failed");

// Same-cycle implication.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: design/rlerx_pkg.sv
package rlerx_pkg;

	localparam int FIELD_W = 16;
	localparam logic [FIELD_W-1:0] ALPHA_RESET = 16'd10;
	localparam logic [FIELD_W-1:0] ALPHA_MIN = 16'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_CHECK,
		ST_DIV,
		ST_DIVEND,
		ST_POP,
		ST_DIRECT
	} state_t;

	typedef struct packed {
		logic take;
		logic load_v;
		logic div_start;
		logic div_step;
		logic push_rem;
		logic push_v;
		logic emit;
		logic emit_direct;
		logic load_pend;
	} cmd_t;

	typedef struct packed {
		logic close_req;
		logic le_base;
		logic v_ge_base;
		logic div_last;
		logic sp_one;
		logic pend2;
	} status_t;

endpackage

FILE: design/rle_radix_expanded_runs.sv
// Run-length encoder: one symbol per input transaction; a closed run is sent as
// (symbol, length) pairs. The length goes out directly when it is at most the
// configured radix (values below two act as two); otherwise it goes out as radix
// digits, most significant first. An input that extends the open run only
// updates the count and leaves the encoder idle. An input that closes a run
// holds in_stall until its pairs are sent. A long run passes through the
// bit-serial restoring divider, which extracts digits least significant first
// into a digit stack, one division per digit past the first. An end mark on a
// new symbol closes two runs, the one-symbol run last. Each pair also waits
// while the output register is stalled. One input is processed at a time;
// the last pair waits in the output register while the next input is taken.
module rle_radix_expanded_runs #(
	parameter int SYMBOL_BITS = 16,
	parameter int RUN_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [15:0] cfg_write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] symbol,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] run_symbol,
	output logic [15:0] length_digit,
	output logic        digit_is_final,
	output logic        batch_last,
	output logic        run_overflow
);
	import rlerx_pkg::*;

	cmd_t    cmd;
	status_t sts;

	rlerx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rlerx_dp #(
		.SYMBOL_BITS (SYMBOL_BITS),
		.RUN_BITS    (RUN_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.symbol         (symbol),
		.stream_end     (stream_end),
		.cmd            (cmd),
		.sts            (sts),
		.run_symbol     (run_symbol),
		.length_digit   (length_digit),
		.digit_is_final (digit_is_final),
		.batch_last     (batch_last),
		.run_overflow   (run_overflow)
	);

endmodule

FILE: design/rlerx_ctrl.sv
`include "assert_macros.svh"

module rlerx_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  rlerx_pkg::status_t sts,
	output rlerx_pkg::cmd_t    cmd
);
	import rlerx_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (sts.close_req) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				if (sts.le_base) begin
					state_d = ST_DIRECT;
				end else begin
					cmd.load_v = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.v_ge_base) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					cmd.push_v = 1'b1;
					state_d    = ST_POP;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DIVEND;
				end
			end
			ST_DIVEND: begin
				cmd.push_rem = 1'b1;
				state_d      = ST_CHECK;
			end
			ST_POP: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					if (sts.sp_one) begin
						if (sts.pend2) begin
							cmd.load_pend = 1'b1;
							state_d       = ST_START;
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_DIRECT: begin
				if (out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_direct = 1'b1;
					if (sts.pend2) begin
						cmd.load_pend = 1'b1;
						state_d       = ST_START;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`CHK_IMPLY(a_emit_free, clk, arst_n, cmd.emit, out_free)
	`CHK_NEXT(a_close_starts, clk, arst_n, cmd.take && sts.close_req, state_q == ST_START)
	`CHK_IMPLY(a_take_idle, clk, arst_n, cmd.take, state_q == ST_IDLE && out_valid_q == out_valid)

endmodule

FILE: design/rlerx_dp.sv
`include "assert_macros.svh"

module rlerx_dp #(
	parameter int SYMBOL_BITS = 16,
	parameter int RUN_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [15:0]        cfg_write_data,
	input  logic [15:0]        symbol,
	input  logic               stream_end,
	input  rlerx_pkg::cmd_t    cmd,
	output rlerx_pkg::status_t sts,
	output logic [15:0]        run_symbol,
	output logic [15:0]        length_digit,
	output logic               digit_is_final,
	output logic               batch_last,
	output logic               run_overflow
);
	import rlerx_pkg::*;

	localparam int CMP_W = (RUN_BITS > FIELD_W) ? RUN_BITS : FIELD_W;
	localparam int SP_W  = $clog2(RUN_BITS + 1);
	localparam int IDX_W = $clog2(RUN_BITS);
	localparam int BC_W  = $clog2(RUN_BITS);
	localparam logic [FIELD_W-1:0] SYM_MASK =
		(SYMBOL_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((1 << SYMBOL_BITS) - 1);
	localparam logic [RUN_BITS-1:0] CNT_ONE = RUN_BITS'(1);

	logic [FIELD_W-1:0]  alpha_q;
	logic [FIELD_W-1:0]  base;

	logic                act_q;
	logic [FIELD_W-1:0]  cur_q;
	logic [RUN_BITS-1:0] cnt_q;
	logic                sat_q;

	logic [FIELD_W-1:0]  snap_sym_q;
	logic [RUN_BITS-1:0] snap_cnt_q;
	logic                snap_sat_q;
	logic                pend2_q;
	logic [FIELD_W-1:0]  pend_sym_q;

	logic [RUN_BITS-1:0] v_q;
	logic [RUN_BITS-1:0] quo_q;
	logic [FIELD_W:0]    rem_q;
	logic [BC_W-1:0]     bit_q;
	logic [FIELD_W-1:0]  stack_q [RUN_BITS];
	logic [SP_W-1:0]     sp_q;
	logic [SP_W-1:0]     sp_m1;

	logic [FIELD_W-1:0]  sym_m;
	logic                cont;
	logic                at_max;
	logic [RUN_BITS-1:0] cnt_next;
	logic                sat_next;
	logic [FIELD_W:0]    shifted;
	logic                div_ge;
	logic                fin;

	assign base     = (alpha_q < ALPHA_MIN) ? ALPHA_MIN : alpha_q;
	assign sym_m    = symbol & SYM_MASK;
	assign cont     = act_q && (sym_m == cur_q);
	assign at_max   = (cnt_q == {RUN_BITS{1'b1}});
	assign cnt_next = at_max ? cnt_q : cnt_q + CNT_ONE;
	assign sat_next = at_max || sat_q;
	assign shifted  = {rem_q[FIELD_W-1:0], quo_q[RUN_BITS-1]};
	assign div_ge   = (shifted >= {1'b0, base});
	assign sp_m1    = sp_q - SP_W'(1);
	assign fin      = cmd.emit_direct || sts.sp_one;

	assign sts.close_req = (!cont && act_q) || stream_end;
	assign sts.le_base   = (CMP_W'(snap_cnt_q) <= CMP_W'(base));
	assign sts.v_ge_base = (CMP_W'(v_q) >= CMP_W'(base));
	assign sts.div_last  = (bit_q == BC_W'(RUN_BITS - 1));
	assign sts.sp_one    = (sp_q == SP_W'(1));
	assign sts.pend2     = pend2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			act_q   <= 1'b0;
			cur_q   <= '0;
			cnt_q   <= '0;
			sat_q   <= 1'b0;
			pend2_q <= 1'b0;
			sp_q    <= '0;
		end else begin
			if (cfg_write_en) begin
				alpha_q <= cfg_write_data;
			end
			if (cmd.take) begin
				if (stream_end) begin
					act_q <= 1'b0;
					cur_q <= '0;
					cnt_q <= '0;
					sat_q <= 1'b0;
				end else if (cont) begin
					cnt_q <= cnt_next;
					sat_q <= sat_next;
				end else begin
					act_q <= 1'b1;
					cur_q <= sym_m;
					cnt_q <= CNT_ONE;
					sat_q <= 1'b0;
				end
				pend2_q <= !cont && act_q && stream_end;
			end
			if (cmd.load_pend) begin
				pend2_q <= 1'b0;
			end
			if (cmd.load_v) begin
				sp_q <= '0;
			end else if (cmd.push_rem || cmd.push_v) begin
				sp_q <= sp_q + SP_W'(1);
			end else if (cmd.emit && !cmd.emit_direct) begin
				sp_q <= sp_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (cont) begin
				snap_sym_q <= cur_q;
				snap_cnt_q <= cnt_next;
				snap_sat_q <= sat_next;
			end else if (act_q) begin
				snap_sym_q <= cur_q;
				snap_cnt_q <= cnt_q;
				snap_sat_q <= sat_q;
			end else begin
				snap_sym_q <= sym_m;
				snap_cnt_q <= CNT_ONE;
				snap_sat_q <= 1'b0;
			end
			pend_sym_q <= sym_m;
		end else if (cmd.load_pend) begin
			snap_sym_q <= pend_sym_q;
			snap_cnt_q <= CNT_ONE;
			snap_sat_q <= 1'b0;
		end

		if (cmd.load_v) begin
			v_q <= snap_cnt_q;
		end else if (cmd.push_rem) begin
			v_q <= quo_q;
		end

		if (cmd.div_start) begin
			quo_q <= v_q;
			rem_q <= '0;
			bit_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[RUN_BITS-2:0], div_ge};
			rem_q <= div_ge ? (shifted - {1'b0, base}) : shifted;
			bit_q <= bit_q + BC_W'(1);
		end

		if (cmd.push_rem) begin
			stack_q[sp_q[IDX_W-1:0]] <= rem_q[FIELD_W-1:0];
		end else if (cmd.push_v) begin
			stack_q[sp_q[IDX_W-1:0]] <= FIELD_W'(v_q);
		end

		if (cmd.emit) begin
			run_symbol     <= snap_sym_q;
			length_digit   <= cmd.emit_direct ? FIELD_W'(snap_cnt_q) :
				stack_q[sp_m1[IDX_W-1:0]];
			digit_is_final <= fin;
			batch_last     <= fin && !pend2_q;
			run_overflow   <= snap_sat_q;
		end
	end

	`CHK_ALWAYS(a_sp_bound, clk, arst_n, sp_q <= SP_W'(RUN_BITS))
	`CHK_IMPLY(a_pop_nonempty, clk, arst_n, cmd.emit && !cmd.emit_direct, sp_q != '0)
	`CHK_IMPLY(a_rem_below_base, clk, arst_n, cmd.div_step, rem_q < {1'b0, base})

endmodule

FILE: dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] sym;
		logic        fin;
		logic        drain;
	} sym_item_t;

	typedef struct packed {
		logic [15:0] sym;
		logic [15:0] digit;
		logic        fin;
		logic        last;
		logic        ovf;
	} run_pair_t;

	localparam int QUIET_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [15:0] cfg_write_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] symbol = '0;
	logic        stream_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] run_symbol;
	logic [15:0] length_digit;
	logic        digit_is_final;
	logic        batch_last;
	logic        run_overflow;

	sym_item_t   pend_q[$];
	run_pair_t   pair_q[$];
	sym_item_t   next_item;
	run_pair_t   want;

	// encoder state as seen by the predictor
	logic [15:0] alphabet = rlerx_pkg::ALPHA_RESET;
	logic        run_open = 1'b0;
	logic [15:0] run_sym = '0;
	logic [15:0] run_len = '0;
	logic        run_sat = 1'b0;

	int unsigned queued = 0;
	int unsigned drain_at = '1;
	int          send_gap = 0;
	int          stall_left = 0;
	int          quiet_cycles = 0;
	int          mismatch_count = 0;
	bit          send_burst = 1'b0;
	bit          recv_burst = 1'b0;

	rle_radix_expanded_runs dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.symbol         (symbol),
		.stream_end     (stream_end),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.run_symbol     (run_symbol),
		.length_digit   (length_digit),
		.digit_is_final (digit_is_final),
		.batch_last     (batch_last),
		.run_overflow   (run_overflow)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void flush_run();
		int unsigned base;
		int unsigned v;
		int unsigned digits[$];
		run_pair_t p;
		if (!run_open)
			return;
		base = (alphabet < 2) ? 2 : alphabet;
		v = run_len;
		p.sym = run_sym;
		p.last = 1'b0;
		p.ovf = run_sat;
		if (v <= base) begin
			p.digit = 16'(v);
			p.fin = 1'b1;
			pair_q.insert(pair_q.size(), p);
			return;
		end
		while (v >= base) begin
			digits.push_front(v % base);
			v = v / base;
		end
		digits.push_front(v);
		foreach (digits[i]) begin
			p.digit = 16'(digits[i]);
			p.fin = (i == digits.size() - 1);
			pair_q.insert(pair_q.size(), p);
		end
	endfunction

	function automatic void encode_symbol(logic [15:0] sym, logic fin);
		int n0;
		run_pair_t p;
		n0 = pair_q.size();
		if (run_open && sym == run_sym) begin
			if (run_len == 16'hFFFF)
				run_sat = 1'b1;
			else
				run_len = run_len + 16'd1;
		end else begin
			flush_run();
			run_open = 1'b1;
			run_sym = sym;
			run_len = 16'd1;
			run_sat = 1'b0;
		end
		if (fin) begin
			flush_run();
			run_open = 1'b0;
			run_sym = '0;
			run_len = '0;
			run_sat = 1'b0;
		end
		if (pair_q.size() > n0) begin
			p = pair_q.pop_back();
			p.last = 1'b1;
			pair_q.insert(pair_q.size(), p);
		end
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] exp_v);
		if (mismatch_count < 100)
			$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp_v);
		mismatch_count++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			symbol <= '0;
			stream_end <= 1'b0;
			send_gap = 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				encode_symbol(symbol, stream_end);
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pend_q.size() > 0 && (!pend_q[0].drain || pair_q.size() == 0)) begin
				next_item = pend_q.pop_front();
				in_valid <= 1'b1;
				symbol <= next_item.sym;
				stream_end <= next_item.fin;
				send_gap = send_burst ? 0 : $urandom_range(0, 4);
				if ($urandom_range(0, 39) == 0)
					send_burst = !send_burst;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pair_q.size() == 0) begin
					report_mismatch("unexpected transaction", run_symbol, length_digit);
				end else begin
					want = pair_q.pop_front();
					if (run_symbol !== want.sym)
						report_mismatch("run_symbol", run_symbol, want.sym);
					if (length_digit !== want.digit)
						report_mismatch("length_digit", length_digit, want.digit);
					if (digit_is_final !== want.fin)
						report_mismatch("digit_is_final", 16'(digit_is_final), 16'(want.fin));
					if (batch_last !== want.last)
						report_mismatch("batch_last", 16'(batch_last), 16'(want.last));
					if (run_overflow !== want.ovf)
						report_mismatch("run_overflow", 16'(run_overflow), 16'(want.ovf));
				end
				stall_left = recv_burst ? 0 : $urandom_range(0, 4);
				if ($urandom_range(0, 39) == 0)
					recv_burst = !recv_burst;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left > 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_item(logic [15:0] sym, logic fin);
		sym_item_t it;
		it.sym = sym;
		it.fin = fin;
		it.drain = (queued == drain_at);
		pend_q.insert(pend_q.size(), it);
		queued++;
	endtask

	task automatic add_run(logic [15:0] sym, int unsigned len, logic fin);
		for (int unsigned k = 1; k <= len; k++)
			push_item(sym, fin && (k == len));
	endtask

	task automatic add_stream(logic [15:0] alpha_v);
		int unsigned base;
		int unsigned lim;
		int unsigned nruns;
		int unsigned len;
		logic [15:0] sym;
		logic [15:0] offs;
		bit wide;
		bit closes;
		base = (alpha_v < 2) ? 2 : alpha_v;
		lim = (base > 20) ? 60 : 3 * base + 2;
		nruns = $urandom_range(1, 6);
		wide = ($urandom_range(0, 2) == 0);
		offs = 16'($urandom);
		closes = ($urandom_range(0, 7) != 0);
		for (int unsigned r = 0; r < nruns; r++) begin
			sym = wide ? 16'($urandom) : offs + 16'($urandom_range(0, 2));
			len = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 4) : $urandom_range(1, lim);
			add_run(sym, len, closes && (r == nruns - 1));
		end
	endtask

	task automatic add_noise();
		int unsigned n;
		n = $urandom_range(1, 6);
		repeat (n)
			push_item(16'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pend_q.size() != 0 || in_valid || pair_q.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_alphabet(logic [15:0] v);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		alphabet = v;
	endtask

	task automatic random_phase(logic [15:0] alpha_v, int unsigned n_items);
		int unsigned start;
		wait_idle();
		write_alphabet(alpha_v);
		start = queued;
		drain_at = start + n_items / 2;
		while (queued - start < n_items) begin
			if ($urandom_range(0, 7) == 0)
				add_noise();
			else
				add_stream(alpha_v);
		end
		push_item(16'($urandom), 1'b1);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset radix: single item, two runs closed by one item, run equal to radix
		push_item(16'h0000, 1'b1);
		add_run(16'hFFFF, 3, 1'b0);
		push_item(16'h5555, 1'b1);
		add_run(16'h1234, 10, 1'b1);

		// radix 1 behaves as 2
		wait_idle();
		write_alphabet(16'd1);
		add_run(16'h1234, 3, 1'b1);
		add_run(16'h00FF, 2, 1'b1);
		add_run(16'hAAAA, 5, 1'b0);
		push_item(16'h5555, 1'b1);

		// radix 0 behaves as 2, then a new symbol ends the stream
		wait_idle();
		write_alphabet(16'd0);
		add_run(16'h8001, 7, 1'b0);
		push_item(16'h7FFE, 1'b1);

		random_phase(16'hFFFF, 50);
		random_phase(16'd2, 50);
		random_phase(16'd3, 50);
		random_phase(16'd10, 50);
		random_phase(16'($urandom_range(4, 40)), 50);
		random_phase(16'($urandom), 50);
		wait_idle();

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
